### rtl/core/stlm_pkg.sv
package stlm_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int KEY_WIDTH_DEF  = 32;
    localparam int PORT_WIDTH     = 32;
    localparam int NUM_KEYS       = 4;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_MERGE      = 2'd2;

endpackage

### rtl/core/stlm_front.sv
module stlm_front #(
    parameter int KEY_WIDTH = stlm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [1:0]                                  opcode,
    input  logic [stlm_pkg::PORT_WIDTH-1:0]             key_a,
    input  logic [stlm_pkg::PORT_WIDTH-1:0]             key_b,
    input  logic [stlm_pkg::PORT_WIDTH-1:0]             key_c,
    input  logic [stlm_pkg::PORT_WIDTH-1:0]             key_d,
    output logic                                        cmd_valid,
    input  logic                                        cmd_ready,
    output logic [1:0]                                  cmd_op,
    output logic [stlm_pkg::NUM_KEYS*KEY_WIDTH-1:0]     cmd_tuple
);
    import stlm_pkg::*;

    localparam int TW = NUM_KEYS * KEY_WIDTH;

    logic [1:0]        op_q   [QUEUE_DEPTH];
    logic [TW-1:0]     tup_q  [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              accept;
    logic              push;
    logic              pop;

    assign busy   = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    // The unused opcode is taken and dropped here, so the back never sees it.
    assign push   = accept && (opcode == OP_LOAD_LEFT || opcode == OP_LOAD_RIGHT
                               || opcode == OP_MERGE);
    assign pop    = cmd_valid && cmd_ready;

    assign cmd_valid = (fill_reg != '0);
    assign cmd_op    = op_q[rd_ptr_reg];
    assign cmd_tuple = tup_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]  <= opcode;
            tup_q[wr_ptr_reg] <= {key_a[KEY_WIDTH-1:0], key_b[KEY_WIDTH-1:0],
                                  key_c[KEY_WIDTH-1:0], key_d[KEY_WIDTH-1:0]};
        end
    end

endmodule

### rtl/core/stlm_back.sv
module stlm_back #(
    parameter int LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEF,
    parameter int KEY_WIDTH  = stlm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cmd_valid,
    output logic                                        cmd_ready,
    input  logic [1:0]                                  cmd_op,
    input  logic [stlm_pkg::NUM_KEYS*KEY_WIDTH-1:0]     cmd_tuple,
    output logic                                        strobe,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_a,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_b,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_c,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_d,
    output logic                                        last_item,
    output logic                                        empty_merge,
    output logic                                        overflowed
);
    import stlm_pkg::*;

    localparam int TW = NUM_KEYS * KEY_WIDTH;
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [TW-1:0] left_mem  [LIST_DEPTH];
    logic [TW-1:0] right_mem [LIST_DEPTH];

    logic          state_reg, state_next;
    logic [CW-1:0] lcnt_reg, lcnt_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;
    logic [CW-1:0] l_reg, l_next;
    logic [CW-1:0] r_reg, r_next;
    logic          drop_reg, drop_next;
    logic [TW-1:0] lrd_reg;
    logic [TW-1:0] rrd_reg;

    logic          strobe_reg, strobe_next;
    logic [TW-1:0] tuple_reg, tuple_next;
    logic          last_reg, last_next;
    logic          empty_reg, empty_next;
    logic          ovf_reg, ovf_next;

    logic          wr_l;
    logic          wr_r;
    logic          l_has;
    logic          r_has;
    logic          take_l;
    logic [CW-1:0] l_adv;
    logic [CW-1:0] r_adv;
    logic          fin;
    logic [AW-1:0] raddr_l;
    logic [AW-1:0] raddr_r;

    // Lexicographic signed compare, key_a (top bits) decides first.
    function automatic logic tuple_less(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic signed [KEY_WIDTH-1:0] ka;
        logic signed [KEY_WIDTH-1:0] kb;
        logic                        lt;
        logic                        decided;
        lt      = 1'b0;
        decided = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            ka = a[(NUM_KEYS-1-i)*KEY_WIDTH +: KEY_WIDTH];
            kb = b[(NUM_KEYS-1-i)*KEY_WIDTH +: KEY_WIDTH];
            if (!decided)
            begin
                if (ka < kb)
                begin
                    lt      = 1'b1;
                    decided = 1'b1;
                end
                else if (ka > kb)
                begin
                    decided = 1'b1;
                end
            end
        end
        return lt;
    endfunction

    assign l_has  = (l_reg < lcnt_reg);
    assign r_has  = (r_reg < rcnt_reg);
    assign take_l = l_has && (!r_has || tuple_less(lrd_reg, rrd_reg));
    assign l_adv  = l_reg + CW'(take_l);
    assign r_adv  = r_reg + CW'(!take_l);
    assign fin    = (l_adv == lcnt_reg) && (r_adv == rcnt_reg);

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        lcnt_next   = lcnt_reg;
        rcnt_next   = rcnt_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        drop_next   = drop_reg;
        strobe_next = 1'b0;
        tuple_next  = lrd_reg;
        last_next   = 1'b0;
        empty_next  = 1'b0;
        ovf_next    = drop_reg;
        wr_l        = 1'b0;
        wr_r        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_op)
                        OP_LOAD_LEFT:
                        begin
                            if (lcnt_reg < DEPTH_C)
                            begin
                                wr_l      = 1'b1;
                                lcnt_next = lcnt_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        OP_LOAD_RIGHT:
                        begin
                            if (rcnt_reg < DEPTH_C)
                            begin
                                wr_r      = 1'b1;
                                rcnt_next = rcnt_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        OP_MERGE:
                        begin
                            if (lcnt_reg == '0 && rcnt_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                tuple_next  = '0;
                                last_next   = 1'b1;
                                empty_next  = 1'b1;
                                drop_next   = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                strobe_next = 1'b1;
                tuple_next  = take_l ? lrd_reg : rrd_reg;
                last_next   = fin;
                l_next      = l_adv;
                r_next      = r_adv;
                if (fin)
                begin
                    state_next = ST_IDLE;
                    l_next     = '0;
                    r_next     = '0;
                    lcnt_next  = '0;
                    rcnt_next  = '0;
                    drop_next  = 1'b0;
                end
            end
        endcase
    end

    // The read heads follow the next indices, so each registered read holds
    // the current head of its list during a merge.
    assign raddr_l = (l_next < DEPTH_C) ? l_next[AW-1:0] : '0;
    assign raddr_r = (r_next < DEPTH_C) ? r_next[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (wr_l)
        begin
            left_mem[lcnt_reg[AW-1:0]] <= cmd_tuple;
        end
        lrd_reg <= left_mem[raddr_l];
    end

    always_ff @(posedge clk)
    begin
        if (wr_r)
        begin
            right_mem[rcnt_reg[AW-1:0]] <= cmd_tuple;
        end
        rrd_reg <= right_mem[raddr_r];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lcnt_reg   <= '0;
            rcnt_reg   <= '0;
            l_reg      <= '0;
            r_reg      <= '0;
            drop_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lcnt_reg   <= lcnt_next;
            rcnt_reg   <= rcnt_next;
            l_reg      <= l_next;
            r_reg      <= r_next;
            drop_reg   <= drop_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tuple_reg <= tuple_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        ovf_reg   <= ovf_next;
    end

    assign strobe      = strobe_reg;
    assign out_a       = PORT_WIDTH'($signed(tuple_reg[3*KEY_WIDTH +: KEY_WIDTH]));
    assign out_b       = PORT_WIDTH'($signed(tuple_reg[2*KEY_WIDTH +: KEY_WIDTH]));
    assign out_c       = PORT_WIDTH'($signed(tuple_reg[KEY_WIDTH +: KEY_WIDTH]));
    assign out_d       = PORT_WIDTH'($signed(tuple_reg[0 +: KEY_WIDTH]));
    assign last_item   = last_reg;
    assign empty_merge = empty_reg;
    assign overflowed  = ovf_reg;

endmodule

### rtl/core/sorted_tuple_list_merge.sv
// Two-way merge of two ascending lists of four-key tuples.
// Commands come in on start/busy: a transfer happens on a clock edge with
// start high and busy low. Opcode 0 appends a tuple to the left list,
// opcode 1 to the right list, opcode 2 merges both lists; opcode 3 is taken
// and ignored. A front stage queues up to four commands; the back stage
// holds both lists in memories and runs one command at a time.
// A load completes when the back takes it, so loads stream at one per
// cycle while no merge occupies the back. A merge of n stored tuples
// emits one result per cycle, the first passing the queue, the back's run
// state and the output registers; while it runs, busy rises once the
// queue is full. A merge of two empty lists emits a single result with
// empty_merge set. Results appear for exactly one cycle with strobe high;
// the receiver cannot stall them. last_item marks the final result.
// Reset empties the queue and both lists and clears the overflow flag.
module sorted_tuple_list_merge #(
    parameter int LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEF,
    parameter int KEY_WIDTH  = stlm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [1:0]                                  opcode,
    input  logic signed [stlm_pkg::PORT_WIDTH-1:0]      key_a,
    input  logic signed [stlm_pkg::PORT_WIDTH-1:0]      key_b,
    input  logic signed [stlm_pkg::PORT_WIDTH-1:0]      key_c,
    input  logic signed [stlm_pkg::PORT_WIDTH-1:0]      key_d,
    output logic                                        strobe,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_a,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_b,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_c,
    output logic signed [stlm_pkg::PORT_WIDTH-1:0]      out_d,
    output logic                                        last_item,
    output logic                                        empty_merge,
    output logic                                        overflowed
);
    import stlm_pkg::*;

    logic                          cmd_valid;
    logic                          cmd_ready;
    logic [1:0]                    cmd_op;
    logic [NUM_KEYS*KEY_WIDTH-1:0] cmd_tuple;

    stlm_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .key_a     (key_a),
        .key_b     (key_b),
        .key_c     (key_c),
        .key_d     (key_d),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_tuple (cmd_tuple)
    );

    stlm_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_op      (cmd_op),
        .cmd_tuple   (cmd_tuple),
        .strobe      (strobe),
        .out_a       (out_a),
        .out_b       (out_b),
        .out_c       (out_c),
        .out_d       (out_d),
        .last_item   (last_item),
        .empty_merge (empty_merge),
        .overflowed  (overflowed)
    );

endmodule
